// ===== design/rdeq_pkg.sv =====
// Package for the ring deque event queue.
// Holds the request and result types, the opcodes and the controller command type.
// Used by every module of the block except rdeq_ram; depends on nothing.
package rdeq_pkg;

    localparam int EVENT_W = 32;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [1:0] OP_PUSH_TAIL = 2'd0;
    localparam logic [1:0] OP_PUSH_HEAD = 2'd1;
    localparam logic [1:0] OP_POP_HEAD  = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [EVENT_W-1:0] event_in;
    } rdeq_in_t;

    typedef struct packed {
        logic               accepted;
        logic [EVENT_W-1:0] event_out;
        logic               is_empty;
        logic               is_full;
    } rdeq_out_t;

    typedef struct packed {
        logic exec;
        logic emit;
    } rdeq_cmd_t;

endpackage

// ===== design/rdeq_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the slot store of the ring deque; depends on nothing.
module rdeq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/rdeq_ctrl.sv =====
// Controller of the ring deque: takes a request and then presents its result.
// Depends on rdeq_pkg for the command type.
module rdeq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    output rdeq_pkg::rdeq_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RESP = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                cmd.emit   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg == ST_RESP);
    assign done = cmd.emit;

endmodule

// ===== design/rdeq_dp.sv =====
// Datapath of the ring deque: capacity register, head and count, slot RAM, result register.
// Depends on rdeq_pkg and rdeq_ram.
module rdeq_dp #(
    parameter int DEPTH      = 16,
    parameter int EVENT_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rdeq_pkg::rdeq_cmd_t            cmd,
    input  rdeq_pkg::rdeq_in_t             request,
    input  logic                           cfg_we,
    input  logic [rdeq_pkg::CAP_W-1:0]     cfg_wdata,
    output rdeq_pkg::rdeq_out_t            result
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = IDX_W + 1;

    logic [rdeq_pkg::CAP_W-1:0] cap_reg;
    logic [IDX_W-1:0]           head_reg;
    logic [IDX_W-1:0]           head_next;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic                       acc_reg;
    logic                       pop_reg;
    logic                       empty_reg;
    logic                       full_reg;

    logic [CNT_W-1:0]      cap_eff;
    logic                  full;
    logic [SUM_W-1:0]      tail_sum;
    logic [IDX_W-1:0]      tail_idx;
    logic [IDX_W-1:0]      prev_head_idx;
    logic [CNT_W-1:0]      pop_sum;
    logic [IDX_W-1:0]      pop_idx;
    logic                  op_ok;
    logic                  pop_ok;
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [EVENT_BITS-1:0] ram_wdata;
    logic [EVENT_BITS-1:0] ram_rdata;

    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (32'(cap_reg) > 32'(DEPTH))
        begin
            cap_eff = CNT_W'(DEPTH);
        end
        else
        begin
            cap_eff = CNT_W'(cap_reg);
        end
    end

    assign full     = (count_reg >= cap_eff);
    assign tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_idx = (tail_sum >= SUM_W'(cap_eff)) ? IDX_W'(tail_sum - SUM_W'(cap_eff))
                                                    : IDX_W'(tail_sum);
    assign prev_head_idx = (head_reg == '0) ? IDX_W'(cap_eff - 1'b1) : head_reg - 1'b1;
    assign pop_sum       = CNT_W'(head_reg) + 1'b1;
    assign pop_idx       = (pop_sum >= cap_eff) ? '0 : IDX_W'(pop_sum);

    always_comb
    begin
        op_ok      = 1'b0;
        pop_ok     = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = tail_idx;
        head_next  = head_reg;
        count_next = count_reg;
        unique case (request.opcode)
            rdeq_pkg::OP_PUSH_TAIL:
            begin
                if (!full)
                begin
                    op_ok      = 1'b1;
                    ram_we     = cmd.exec;
                    count_next = count_reg + 1'b1;
                end
            end
            rdeq_pkg::OP_PUSH_HEAD:
            begin
                ram_waddr = prev_head_idx;
                if (!full)
                begin
                    op_ok      = 1'b1;
                    ram_we     = cmd.exec;
                    head_next  = prev_head_idx;
                    count_next = count_reg + 1'b1;
                end
            end
            rdeq_pkg::OP_POP_HEAD:
            begin
                if (count_reg != '0)
                begin
                    op_ok      = 1'b1;
                    pop_ok     = 1'b1;
                    head_next  = pop_idx;
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                op_ok = 1'b0;
            end
        endcase
    end

    assign ram_wdata = EVENT_BITS'(request.event_in);

    rdeq_ram #(
        .WIDTH (EVENT_BITS),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= rdeq_pkg::CAP_RESET;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (cmd.exec)
            begin
                head_reg  <= head_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            acc_reg   <= op_ok;
            pop_reg   <= pop_ok;
            empty_reg <= (count_next == '0);
            full_reg  <= (count_next >= cap_eff);
        end
    end

    assign result.accepted  = acc_reg;
    assign result.event_out = pop_reg ? rdeq_pkg::EVENT_W'(ram_rdata) : '0;
    assign result.is_empty  = empty_reg;
    assign result.is_full   = full_reg;

`ifndef SYNTHESIS
    // The count can never grow past the built depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(DEPTH))
        else $error("rdeq_dp: entry count exceeds depth");

    // The head pointer always addresses a real slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(head_reg) < 32'(DEPTH))
        else $error("rdeq_dp: head index out of range");

    // A performed pop removes exactly one entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && pop_ok |=> count_reg == $past(count_reg) - 1'b1)
        else $error("rdeq_dp: pop did not decrement the count");

    // A refused request leaves head and count untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && !op_ok |=> head_reg == $past(head_reg) && count_reg == $past(count_reg))
        else $error("rdeq_dp: refused request changed the queue");
`endif

endmodule

// ===== design/ring_deque_event_queue.sv =====
// Ring deque event queue: a circular event buffer that takes pushes at both ends and pops
// at the head. For each request, start is sampled while busy is low, then
// busy is high for the following cycle while the slot RAM's registered read completes,
// and in that cycle done is high for exactly one clock with the result on the result port.
// The receiver cannot stall, so the result must be captured while done is high. A push
// while full or a pop while empty is refused with accepted low and event_out zero. The
// capacity register is written through cfg_we and cfg_wdata and should only be changed
// while the queue is idle; zero acts as one and values above DEPTH act as DEPTH.
// Depends on rdeq_pkg, rdeq_ctrl, rdeq_dp and rdeq_ram.
module ring_deque_event_queue #(
    parameter int DEPTH      = 16,
    parameter int EVENT_BITS = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  rdeq_pkg::rdeq_in_t         request,
    output logic                       done,
    output rdeq_pkg::rdeq_out_t        result,
    input  logic                       cfg_we,
    input  logic [rdeq_pkg::CAP_W-1:0] cfg_wdata
);

    rdeq_pkg::rdeq_cmd_t cmd;

    rdeq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    rdeq_dp #(
        .DEPTH      (DEPTH),
        .EVENT_BITS (EVENT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .request   (request),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .result    (result)
    );

endmodule

// ===== tb/ring_deque_event_queue_checker.sv =====
// Checker for the ring deque event queue: watches the request, result and capacity ports.
// It mirrors the queue state, predicts one result per request taken while busy is low and compares it.
// Depends on rdeq_pkg.
module ring_deque_event_queue_checker #(
    parameter int DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  rdeq_pkg::rdeq_in_t         request,
    input  logic                       done,
    input  rdeq_pkg::rdeq_out_t        result,
    input  logic                       cfg_we,
    input  logic [rdeq_pkg::CAP_W-1:0] cfg_wdata,
    output int                         outstanding,
    output int                         fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [rdeq_pkg::EVENT_W-1:0] slot_mirror [DEPTH];
    int unsigned                  mirror_head;
    int unsigned                  mirror_count;
    logic [rdeq_pkg::CAP_W-1:0]   mirror_cap;
    rdeq_pkg::rdeq_out_t          expected_results [$];
    rdeq_pkg::rdeq_out_t          oldest_result;

    function automatic int unsigned usable_capacity();
        int unsigned cap;
        cap = 32'(mirror_cap);
        if (cap == 0)
        begin
            cap = 1;
        end
        if (cap > DEPTH)
        begin
            cap = DEPTH;
        end
        return cap;
    endfunction

    function automatic rdeq_pkg::rdeq_out_t apply_queue_op(rdeq_pkg::rdeq_in_t req);
        int unsigned         cap;
        int unsigned         idx;
        rdeq_pkg::rdeq_out_t res;
        cap = usable_capacity();
        res = '0;
        unique case (req.opcode)
            rdeq_pkg::OP_PUSH_TAIL:
            begin
                if (mirror_count < cap)
                begin
                    idx = mirror_head + mirror_count;
                    if (idx >= cap)
                    begin
                        idx = idx - cap;
                    end
                    slot_mirror[idx] = req.event_in;
                    mirror_count++;
                    res.accepted = 1'b1;
                end
            end
            rdeq_pkg::OP_PUSH_HEAD:
            begin
                if (mirror_count < cap)
                begin
                    idx = (mirror_head == 0) ? cap - 1 : mirror_head - 1;
                    slot_mirror[idx] = req.event_in;
                    mirror_head = idx;
                    mirror_count++;
                    res.accepted = 1'b1;
                end
            end
            rdeq_pkg::OP_POP_HEAD:
            begin
                if (mirror_count != 0)
                begin
                    res.event_out = slot_mirror[mirror_head];
                    idx = mirror_head + 1;
                    if (idx >= cap)
                    begin
                        idx = 0;
                    end
                    mirror_head = idx;
                    mirror_count--;
                    res.accepted = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        res.is_empty = (mirror_count == 0);
        res.is_full  = (mirror_count >= cap);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [rdeq_pkg::EVENT_W-1:0] got,
                                   logic [rdeq_pkg::EVENT_W-1:0] want);
        $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                slot_mirror[i] = '0;
            end
            mirror_head  = 0;
            mirror_count = 0;
            mirror_cap   = rdeq_pkg::CAP_RESET;
            expected_results.delete();
            fail_count   = 0;
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result with no request outstanding",
                                    result.event_out, '0);
                end
                else
                begin
                    oldest_result = expected_results.pop_front();
                    if (result.accepted !== oldest_result.accepted)
                    begin
                        report_mismatch("accepted", 32'(result.accepted),
                                        32'(oldest_result.accepted));
                    end
                    if (result.event_out !== oldest_result.event_out)
                    begin
                        report_mismatch("event_out", result.event_out, oldest_result.event_out);
                    end
                    if (result.is_empty !== oldest_result.is_empty)
                    begin
                        report_mismatch("is_empty", 32'(result.is_empty),
                                        32'(oldest_result.is_empty));
                    end
                    if (result.is_full !== oldest_result.is_full)
                    begin
                        report_mismatch("is_full", 32'(result.is_full),
                                        32'(oldest_result.is_full));
                    end
                end
            end
            if (cfg_we)
            begin
                mirror_cap = cfg_wdata;
            end
            if (start && !busy)
            begin
                expected_results.push_back(apply_queue_op(request));
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

// ===== tb/ring_deque_event_queue_tb.sv =====
// Top of the ring deque event queue testbench: clock, reset and request stimulus.
// Runs directed and random phases over many capacities; the checker does the comparing.
// Depends on rdeq_pkg, ring_deque_event_queue and ring_deque_event_queue_checker.
module ring_deque_event_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam int         ITEM_COUNT    = 1900;
    localparam int         QUIET_TAIL    = 1700;
    localparam int         MODE_FILL     = 0;
    localparam int         MODE_DRAIN    = 1;
    localparam int         MODE_BALANCED = 2;
    localparam int         MODE_SWEEP    = 3;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       start     = 1'b0;
    rdeq_pkg::rdeq_in_t         request   = '0;
    logic                       cfg_we    = 1'b0;
    logic [rdeq_pkg::CAP_W-1:0] cfg_wdata = '0;
    logic                       busy;
    logic                       done;
    rdeq_pkg::rdeq_out_t        result;
    int                         outstanding;
    int                         fail_count;
    int                         items_sent = 0;

    ring_deque_event_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    ring_deque_event_queue_checker checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .done        (done),
        .result      (result),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_request(logic [1:0] opcode, logic [rdeq_pkg::EVENT_W-1:0] event_word);
        request <= {opcode, event_word};
        start   <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        if (opcode != OP_UNUSED)
        begin
            items_sent++;
        end
    endtask

    task automatic idle_gap();
        start <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(logic [rdeq_pkg::CAP_W-1:0] cap_value);
        cfg_wdata <= cap_value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [rdeq_pkg::EVENT_W-1:0] random_event();
        int unsigned pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
        begin
            return '0;
        end
        if (pick == 1)
        begin
            return '1;
        end
        return $urandom();
    endfunction

    // The fill mode favors pushes, the drain mode favors pops, the sweep mode alternates.
    task automatic run_phase(int n_items, int mode, int gap_pct, bit hold_midway);
        int unsigned roll;
        int          push_pct;
        logic [1:0]  opcode;
        for (int i = 0; i < n_items; i++)
        begin
            case (mode)
                MODE_FILL:     push_pct = 75;
                MODE_DRAIN:    push_pct = 25;
                MODE_BALANCED: push_pct = 50;
                default:       push_pct = ((i / 24) % 2 == 0) ? 90 : 10;
            endcase
            roll = $urandom_range(0, 99);
            if (roll < 3)
            begin
                opcode = OP_UNUSED;
            end
            else if ($urandom_range(0, 99) < push_pct)
            begin
                opcode = $urandom_range(0, 1) ? rdeq_pkg::OP_PUSH_HEAD : rdeq_pkg::OP_PUSH_TAIL;
            end
            else
            begin
                opcode = rdeq_pkg::OP_POP_HEAD;
            end
            send_request(opcode, random_event());
            if (hold_midway && i == n_items / 2)
            begin
                wait_drained();
            end
            else if (items_sent < QUIET_TAIL && $urandom_range(0, 99) < gap_pct)
            begin
                idle_gap();
            end
        end
    endtask

    initial
    begin
        int                         phase;
        int                         drain_cycles;
        int                         gap_pct;
        logic [rdeq_pkg::CAP_W-1:0] cap_value;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_capacity(rdeq_pkg::CAP_RESET);
        @(posedge clk);

        // Wrap of a head push from slot zero, then a fill that writes every slot.
        send_request(rdeq_pkg::OP_POP_HEAD, 32'h1234_5678);
        send_request(OP_UNUSED, 32'hDEAD_BEEF);
        send_request(rdeq_pkg::OP_PUSH_HEAD, 32'hFFFF_FFFF);
        send_request(rdeq_pkg::OP_PUSH_TAIL, 32'h0000_0000);
        send_request(rdeq_pkg::OP_PUSH_TAIL, 32'h0000_0001);
        send_request(rdeq_pkg::OP_PUSH_TAIL, 32'h8000_0000);
        send_request(rdeq_pkg::OP_PUSH_TAIL, 32'hAAAA_AAAA);
        send_request(rdeq_pkg::OP_PUSH_TAIL, 32'h5555_5555);
        for (int i = 0; i < 10; i++)
        begin
            send_request(rdeq_pkg::OP_PUSH_TAIL, $urandom());
        end
        send_request(rdeq_pkg::OP_PUSH_TAIL, 32'h0BAD_F00D);
        send_request(rdeq_pkg::OP_PUSH_HEAD, 32'hC0FF_EE00);
        send_request(OP_UNUSED, 32'hFFFF_FFFF);
        send_request(rdeq_pkg::OP_POP_HEAD, 32'hFFFF_FFFF);
        send_request(rdeq_pkg::OP_POP_HEAD, 32'h0000_0000);
        send_request(rdeq_pkg::OP_POP_HEAD, 32'h0000_0000);

        phase = 0;
        while (items_sent < ITEM_COUNT)
        begin
            wait_drained();
            case (phase)
                0:       cap_value = 5'd1;
                1:       cap_value = 5'd0;
                2:       cap_value = 5'd31;
                3:       cap_value = 5'd16;
                4:       cap_value = 5'd17;
                5:       cap_value = 5'd2;
                6:       cap_value = 5'd15;
                default: cap_value = rdeq_pkg::CAP_W'($urandom_range(0, 31));
            endcase
            write_capacity(cap_value);
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 10;
                default: gap_pct = 35;
            endcase
            run_phase($urandom_range(60, 140), $urandom_range(MODE_FILL, MODE_SWEEP), gap_pct,
                      phase == 3);
            phase++;
        end

        start <= 1'b0;
        drain_cycles = 0;
        do
        begin
            @(posedge clk);
            drain_cycles++;
        end
        while (outstanding != 0 && drain_cycles < 2000);
        repeat (4) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
